[rtl/c6502_pkg.sv]
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types, codes and decode helpers for the 6502-style execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package c6502_pkg;

   localparam int MEM_BYTES_DEF = 65536;

   // Configuration register byte address (word index 0).
   localparam logic [2:0] CSR_ENTRY_ADDR = 3'd0;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_EXEC    = 2'd2,
      FUNC_RESTART = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      M_IMM  = 4'd0,
      M_ZP   = 4'd1,
      M_ZPX  = 4'd2,
      M_ZPY  = 4'd3,
      M_ABS  = 4'd4,
      M_ABSX = 4'd5,
      M_ABSY = 4'd6,
      M_INDX = 4'd7,
      M_INDY = 4'd8,
      M_ACC  = 4'd9,
      M_BAD  = 4'd10
   } mode_type;

   // Status flag bit positions.
   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_I = 2;
   localparam int FL_D = 3;
   localparam int FL_V = 6;
   localparam int FL_N = 7;

   localparam logic [7:0] PUSH_STATUS_SET = 8'h30;
   localparam logic [7:0] PULL_KEEP_MASK  = 8'h30;
   localparam logic [7:0] PULL_TAKE_MASK  = 8'hCF;
   localparam logic [7:0] BIT_KEEP_MASK   = 8'h3D;
   localparam logic [7:0] BIT_TAKE_MASK   = 8'hC0;
   localparam logic [15:0] IRQ_VECTOR     = 16'hFFFE;

   // Opcodes handled outside the regular addressing-mode grid.
   localparam logic [7:0] OP_BRK = 8'h00;
   localparam logic [7:0] OP_JSR = 8'h20;
   localparam logic [7:0] OP_RTI = 8'h40;
   localparam logic [7:0] OP_RTS = 8'h60;
   localparam logic [7:0] OP_JMP = 8'h4C;
   localparam logic [7:0] OP_JMI = 8'h6C;
   localparam logic [7:0] OP_PHP = 8'h08;
   localparam logic [7:0] OP_PLP = 8'h28;
   localparam logic [7:0] OP_PHA = 8'h48;
   localparam logic [7:0] OP_PLA = 8'h68;
   localparam logic [7:0] OP_CLC = 8'h18;
   localparam logic [7:0] OP_SEC = 8'h38;
   localparam logic [7:0] OP_CLI = 8'h58;
   localparam logic [7:0] OP_SEI = 8'h78;
   localparam logic [7:0] OP_CLV = 8'hB8;
   localparam logic [7:0] OP_CLD = 8'hD8;
   localparam logic [7:0] OP_SED = 8'hF8;
   localparam logic [7:0] OP_DEY = 8'h88;
   localparam logic [7:0] OP_INY = 8'hC8;
   localparam logic [7:0] OP_DEX = 8'hCA;
   localparam logic [7:0] OP_INX = 8'hE8;
   localparam logic [7:0] OP_TXA = 8'h8A;
   localparam logic [7:0] OP_TYA = 8'h98;
   localparam logic [7:0] OP_TAY = 8'hA8;
   localparam logic [7:0] OP_TAX = 8'hAA;
   localparam logic [7:0] OP_TSX = 8'hBA;
   localparam logic [7:0] OP_TXS = 8'h9A;
   localparam logic [7:0] OP_NOP = 8'hEA;
   localparam logic [7:0] OP_STA_IMM = 8'h89;

   function automatic logic is_special(input logic [7:0] op);
      logic hit;
      case (op)
         OP_BRK, OP_JSR, OP_RTI, OP_RTS, OP_JMP, OP_JMI, OP_PHP, OP_PLP,
         OP_PHA, OP_PLA, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD,
         OP_SED, OP_DEY, OP_INY, OP_DEX, OP_INX, OP_TXA, OP_TYA, OP_TAY,
         OP_TAX, OP_TSX, OP_TXS, OP_NOP: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic mode_type decode_mode(input logic [7:0] op);
      logic [1:0] cc;
      logic [2:0] aaa;
      logic [2:0] bbb;
      mode_type   m;
      mode_type   res;
      cc  = op[1:0];
      aaa = op[7:5];
      bbb = op[4:2];
      res = M_BAD;
      if (cc == 2'd1) begin
         case (bbb)
            3'd0: res = M_INDX;
            3'd1: res = M_ZP;
            3'd2: res = (op == OP_STA_IMM) ? M_BAD : M_IMM;
            3'd3: res = M_ABS;
            3'd4: res = M_INDY;
            3'd5: res = M_ZPX;
            3'd6: res = M_ABSY;
            default: res = M_ABSX;
         endcase
      end else if (cc == 2'd2) begin
         case (bbb)
            3'd0: res = (aaa == 3'd5) ? M_IMM : M_BAD;
            3'd1: res = M_ZP;
            3'd2: res = (aaa < 3'd4) ? M_ACC : M_BAD;
            3'd3: res = M_ABS;
            3'd5: res = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
            3'd7: res = (aaa == 3'd5) ? M_ABSY : ((aaa == 3'd4) ? M_BAD : M_ABSX);
            default: res = M_BAD;
         endcase
      end else if (cc == 2'd0) begin
         case (bbb)
            3'd0: m = M_IMM;
            3'd1: m = M_ZP;
            3'd3: m = M_ABS;
            3'd5: m = M_ZPX;
            3'd7: m = M_ABSX;
            default: m = M_BAD;
         endcase
         case (aaa)
            3'd1: res = (bbb == 3'd1 || bbb == 3'd3) ? m : M_BAD;
            3'd4: res = (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) ? m : M_BAD;
            3'd5: res = m;
            3'd6, 3'd7: res = (bbb <= 3'd3) ? m : M_BAD;
            default: res = M_BAD;
         endcase
      end
      return res;
   endfunction

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q       = p;
      q[FL_N] = v[7];
      q[FL_Z] = (v == 8'h00);
      return q;
   endfunction

   function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] r,
                                            input logic [7:0] m);
      logic [7:0] q;
      q       = set_nz(p, r - m);
      q[FL_C] = (r >= m);
      return q;
   endfunction

endpackage

`default_nettype wire

[rtl/c6502_ifs.sv]
// ----------------------------------------------------------------------------
// c6502 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface c6502_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output func, output address, output write_data,
                   input ready);
   modport sink   (input valid, input func, input address, input write_data,
                   output ready);
endinterface

interface c6502_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [7:0]  accumulator;
   logic [7:0]  index_x;
   logic [7:0]  index_y;
   logic [7:0]  stack_pointer;
   logic [7:0]  status_flags;
   logic [15:0] program_counter;
   logic [7:0]  executed_opcode;
   logic        bad_opcode;

   modport source (output valid, output read_data, output accumulator, output index_x,
                   output index_y, output stack_pointer, output status_flags,
                   output program_counter, output executed_opcode, output bad_opcode,
                   input ready);
   modport sink   (input valid, input read_data, input accumulator, input index_x,
                   input index_y, input stack_pointer, input status_flags,
                   input program_counter, input executed_opcode, input bad_opcode,
                   output ready);
endinterface

`default_nettype wire

[rtl/cpu6502_instruction_execute.sv]
// ----------------------------------------------------------------------------
// cpu6502_instruction_execute
// 6502-style core (binary arithmetic) with a private single-port byte memory.
// ----------------------------------------------------------------------------
//  channel   direction  role
//  req_bus   in         write, read, execute or restart item
//  rsp_bus   out        one result item per request item
//  csr_*     in/out     APB register port, entry_address at byte 0
//
//  A memory write or restart goes straight to the posting state, a memory read
//  passes through one read state first, and an instruction takes one state per
//  access of the single memory port (opcode, operands, pointers, operand, stack) plus a state to post the result.
//  Reset is synchronous and loads the CPU registers (A, X, Y, PC zero, SP $FD, P $24); memory is not cleared.
//  A new item is taken while the previous result waits in the output register;
//  an item only stalls in its final cycle if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_instruction_execute #(
   parameter int MEM_BYTES = c6502_pkg::MEM_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   c6502_req_if.sink        req_bus,
   c6502_rsp_if.source      rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import c6502_pkg::*;

   // MEM_BYTES is a power of two; addresses keep their low bits.
   localparam int AW = $clog2(MEM_BYTES);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_MRD  = 11'b000_0000_0010,
      S_OPC  = 11'b000_0000_0100,
      S_B1   = 11'b000_0000_1000,
      S_B2   = 11'b000_0001_0000,
      S_PTR1 = 11'b000_0010_0000,
      S_PTR2 = 11'b000_0100_0000,
      S_EA   = 11'b000_1000_0000,
      S_OPER = 11'b001_0000_0000,
      S_SEQ  = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   logic [7:0] mem_ff [MEM_BYTES];
   logic [7:0] mem_rd_ff;

   state_type   state_ff, state_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in, entry_ff;
   logic [7:0]  op_ff, op_in, b1_ff, b1_in, lo_ff, lo_in, ptr_ff, ptr_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [15:0] ea_ff, ea_in;
   logic [2:0]  step_ff, step_in;
   logic        bad_ff, bad_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mem_we;
   logic [15:0] mem_addr;
   logic [7:0]  mem_wdata;

   logic        req_fire, rsp_load, csr_write;
   mode_type    mode;
   logic [1:0]  cc;
   logic [2:0]  aaa;
   logic        is_abs;
   logic [15:0] pc_next;
   logic [7:0]  store_val;
   logic [7:0]  m_val;
   logic [7:0]  alu_a, alu_x, alu_y, alu_p, alu_r;
   logic        alu_wr;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ENTRY_ADDR) ? {16'h0000, entry_ff} : 32'h0;

   assign mode   = decode_mode(op_ff);
   assign cc     = op_ff[1:0];
   assign aaa    = op_ff[7:5];
   assign is_abs = (mode == M_ABS) || (mode == M_ABSX) || (mode == M_ABSY);
   assign pc_next = pc_ff + ((mode == M_ACC) ? 16'd1 : (is_abs ? 16'd3 : 16'd2));
   assign store_val = (cc == 2'd1) ? a_ff : ((cc == 2'd2) ? x_ff : y_ff);
   assign m_val  = (mode == M_ACC) ? a_ff : mem_rd_ff;

   // Byte memory: one access per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr[AW-1:0]] <= mem_wdata;
      end
      mem_rd_ff <= mem_ff[mem_addr[AW-1:0]];
   end

   // Operate on one data byte for the regular opcode grid.
   always_comb begin
      logic [8:0] sum;
      logic [7:0] mo;
      alu_a = a_ff; alu_x = x_ff; alu_y = y_ff; alu_p = p_ff;
      alu_r = 8'h00; alu_wr = 1'b0;
      sum = 9'h000; mo = m_val;
      case (cc)
         2'd1: begin
            case (aaa)
               3'd0: begin alu_a = a_ff | m_val; alu_p = set_nz(p_ff, alu_a); end
               3'd1: begin alu_a = a_ff & m_val; alu_p = set_nz(p_ff, alu_a); end
               3'd2: begin alu_a = a_ff ^ m_val; alu_p = set_nz(p_ff, alu_a); end
               3'd3, 3'd7: begin
                  mo = (aaa == 3'd7) ? ~m_val : m_val;
                  sum = {1'b0, a_ff} + {1'b0, mo} + {8'h00, p_ff[FL_C]};
                  alu_a = sum[7:0];
                  alu_p = set_nz(p_ff, alu_a);
                  alu_p[FL_V] = ~(a_ff[7] ^ mo[7]) & (a_ff[7] ^ alu_a[7]);
                  alu_p[FL_C] = sum[8];
               end
               3'd5: begin alu_a = m_val; alu_p = set_nz(p_ff, m_val); end
               3'd6: alu_p = cmp_flags(p_ff, a_ff, m_val);
               default: ;
            endcase
         end
         2'd2: begin
            case (aaa)
               3'd0: begin alu_r = {m_val[6:0], 1'b0}; alu_p[FL_C] = m_val[7]; end
               3'd1: begin alu_r = {m_val[6:0], p_ff[FL_C]}; alu_p[FL_C] = m_val[7]; end
               3'd2: begin alu_r = {1'b0, m_val[7:1]}; alu_p[FL_C] = m_val[0]; end
               3'd3: begin alu_r = {p_ff[FL_C], m_val[7:1]}; alu_p[FL_C] = m_val[0]; end
               3'd6: alu_r = m_val - 8'd1;
               3'd7: alu_r = m_val + 8'd1;
               default: ;
            endcase
            if (aaa == 3'd5) begin
               alu_x = m_val;
               alu_p = set_nz(p_ff, m_val);
            end else if (aaa != 3'd4) begin
               alu_p = set_nz(alu_p, alu_r);
               if (mode == M_ACC) begin
                  alu_a = alu_r;
               end else begin
                  alu_wr = 1'b1;
               end
            end
         end
         default: begin
            case (aaa)
               3'd1: begin
                  alu_p = (p_ff & BIT_KEEP_MASK) | (m_val & BIT_TAKE_MASK);
                  alu_p[FL_Z] = ((a_ff & m_val) == 8'h00);
               end
               3'd5: begin alu_y = m_val; alu_p = set_nz(p_ff, m_val); end
               3'd6: alu_p = cmp_flags(p_ff, y_ff, m_val);
               3'd7: alu_p = cmp_flags(p_ff, x_ff, m_val);
               default: ;
            endcase
         end
      endcase
   end

   // Sequencer: one memory access per state.
   always_comb begin
      logic [15:0] w;
      logic        flag;
      state_in = state_ff;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; p_in = p_ff; pc_in = pc_ff;
      op_in = op_ff; b1_in = b1_ff; lo_in = lo_ff; ptr_in = ptr_ff; ea_in = ea_ff;
      step_in = step_ff; rdata_in = rdata_ff; bad_in = bad_ff;
      mem_we = 1'b0; mem_addr = 16'h0000; mem_wdata = 8'h00;
      w = {mem_rd_ff, b1_ff};
      flag = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rdata_in = 8'h00;
               op_in    = 8'h00;
               bad_in   = 1'b0;
               case (func_type'(req_bus.func))
                  FUNC_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = req_bus.address;
                     mem_wdata = req_bus.write_data;
                     state_in  = S_DONE;
                  end
                  FUNC_READ: begin
                     mem_addr = req_bus.address;
                     state_in = S_MRD;
                  end
                  FUNC_EXEC: begin
                     mem_addr = pc_ff;
                     state_in = S_OPC;
                  end
                  default: begin
                     pc_in    = entry_ff;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MRD: begin
            rdata_in = mem_rd_ff;
            state_in = S_DONE;
         end
         S_OPC: begin
            op_in    = mem_rd_ff;
            mem_addr = pc_ff + 16'd1;
            state_in = S_B1;
         end
         S_B1: begin
            b1_in    = mem_rd_ff;
            state_in = S_DONE;
            if (op_ff[4:0] == 5'b10000) begin
               case (op_ff[7:6])
                  2'd0: flag = p_ff[FL_N];
                  2'd1: flag = p_ff[FL_V];
                  2'd2: flag = p_ff[FL_C];
                  default: flag = p_ff[FL_Z];
               endcase
               pc_in = pc_ff + 16'd2;
               if (flag == op_ff[5]) begin
                  pc_in = pc_ff + 16'd2 + {{8{mem_rd_ff[7]}}, mem_rd_ff};
               end
            end else if (is_special(op_ff)) begin
               pc_in = pc_ff + 16'd1;
               case (op_ff)
                  OP_BRK, OP_RTI, OP_RTS, OP_PLP, OP_PLA: begin
                     pc_in    = pc_ff;
                     step_in  = 3'd0;
                     state_in = S_SEQ;
                  end
                  OP_JSR, OP_JMP, OP_JMI: begin
                     pc_in    = pc_ff;
                     mem_addr = pc_ff + 16'd2;
                     state_in = S_B2;
                  end
                  OP_PHP, OP_PHA: begin
                     mem_we    = 1'b1;
                     mem_addr  = {8'h01, sp_ff};
                     mem_wdata = (op_ff == OP_PHP) ? (p_ff | PUSH_STATUS_SET) : a_ff;
                     sp_in     = sp_ff - 8'd1;
                  end
                  OP_CLC: p_in[FL_C] = 1'b0;
                  OP_SEC: p_in[FL_C] = 1'b1;
                  OP_CLI: p_in[FL_I] = 1'b0;
                  OP_SEI: p_in[FL_I] = 1'b1;
                  OP_CLV: p_in[FL_V] = 1'b0;
                  OP_CLD: p_in[FL_D] = 1'b0;
                  OP_SED: p_in[FL_D] = 1'b1;
                  OP_DEY: begin y_in = y_ff - 8'd1; p_in = set_nz(p_ff, y_in); end
                  OP_INY: begin y_in = y_ff + 8'd1; p_in = set_nz(p_ff, y_in); end
                  OP_DEX: begin x_in = x_ff - 8'd1; p_in = set_nz(p_ff, x_in); end
                  OP_INX: begin x_in = x_ff + 8'd1; p_in = set_nz(p_ff, x_in); end
                  OP_TXA: begin a_in = x_ff; p_in = set_nz(p_ff, x_ff); end
                  OP_TYA: begin a_in = y_ff; p_in = set_nz(p_ff, y_ff); end
                  OP_TAY: begin y_in = a_ff; p_in = set_nz(p_ff, a_ff); end
                  OP_TAX: begin x_in = a_ff; p_in = set_nz(p_ff, a_ff); end
                  OP_TSX: begin x_in = sp_ff; p_in = set_nz(p_ff, sp_ff); end
                  OP_TXS: sp_in = x_ff;
                  default: ;
               endcase
            end else begin
               case (mode)
                  M_IMM, M_ACC: begin
                     a_in = alu_a; x_in = alu_x; y_in = alu_y; p_in = alu_p;
                     pc_in = pc_next;
                  end
                  M_ZP: begin ea_in = {8'h00, mem_rd_ff}; state_in = S_EA; end
                  M_ZPX: begin ea_in = {8'h00, mem_rd_ff + x_ff}; state_in = S_EA; end
                  M_ZPY: begin ea_in = {8'h00, mem_rd_ff + y_ff}; state_in = S_EA; end
                  M_ABS, M_ABSX, M_ABSY: begin
                     mem_addr = pc_ff + 16'd2;
                     state_in = S_B2;
                  end
                  M_INDX: begin
                     ptr_in   = mem_rd_ff + x_ff;
                     mem_addr = {8'h00, ptr_in};
                     state_in = S_PTR1;
                  end
                  M_INDY: begin
                     ptr_in   = mem_rd_ff;
                     mem_addr = {8'h00, mem_rd_ff};
                     state_in = S_PTR1;
                  end
                  default: bad_in = 1'b1;
               endcase
            end
         end
         S_B2: begin
            case (op_ff)
               OP_JMP: begin pc_in = w; state_in = S_DONE; end
               OP_JMI: begin ea_in = w; mem_addr = w; state_in = S_PTR1; end
               OP_JSR: begin ea_in = w; step_in = 3'd0; state_in = S_SEQ; end
               default: begin
                  if (mode == M_ABSX) begin
                     ea_in = w + {8'h00, x_ff};
                  end else if (mode == M_ABSY) begin
                     ea_in = w + {8'h00, y_ff};
                  end else begin
                     ea_in = w;
                  end
                  state_in = S_EA;
               end
            endcase
         end
         S_PTR1: begin
            lo_in = mem_rd_ff;
            if (op_ff == OP_JMI) begin
               // The pointer high byte is read within the same page.
               mem_addr = {ea_ff[15:8], ea_ff[7:0] + 8'd1};
            end else begin
               mem_addr = {8'h00, ptr_ff + 8'd1};
            end
            state_in = S_PTR2;
         end
         S_PTR2: begin
            if (op_ff == OP_JMI) begin
               pc_in    = {mem_rd_ff, lo_ff};
               state_in = S_DONE;
            end else begin
               ea_in = {mem_rd_ff, lo_ff};
               if (mode == M_INDY) begin
                  ea_in = {mem_rd_ff, lo_ff} + {8'h00, y_ff};
               end
               state_in = S_EA;
            end
         end
         S_EA: begin
            pc_in    = pc_next;
            mem_addr = ea_ff;
            if (aaa == 3'd4) begin
               mem_we    = 1'b1;
               mem_wdata = store_val;
               state_in  = S_DONE;
            end else begin
               state_in = S_OPER;
            end
         end
         S_OPER: begin
            a_in = alu_a; x_in = alu_x; y_in = alu_y; p_in = alu_p;
            mem_we    = alu_wr;
            mem_addr  = ea_ff;
            mem_wdata = alu_r;
            state_in  = S_DONE;
         end
         S_SEQ: begin
            step_in = step_ff + 3'd1;
            w = pc_ff + 16'd2;
            case (op_ff)
               OP_BRK, OP_JSR: begin
                  case (step_ff)
                     3'd0: begin
                        mem_we = 1'b1; mem_addr = {8'h01, sp_ff}; mem_wdata = w[15:8];
                        sp_in = sp_ff - 8'd1;
                     end
                     3'd1: begin
                        mem_we = 1'b1; mem_addr = {8'h01, sp_ff}; mem_wdata = w[7:0];
                        sp_in = sp_ff - 8'd1;
                        if (op_ff == OP_JSR) begin
                           pc_in    = ea_ff;
                           state_in = S_DONE;
                        end
                     end
                     3'd2: begin
                        mem_we = 1'b1; mem_addr = {8'h01, sp_ff};
                        mem_wdata = p_ff | PUSH_STATUS_SET;
                        sp_in = sp_ff - 8'd1;
                        p_in[FL_I] = 1'b1;
                     end
                     3'd3: mem_addr = IRQ_VECTOR;
                     3'd4: begin lo_in = mem_rd_ff; mem_addr = IRQ_VECTOR + 16'd1; end
                     default: begin pc_in = {mem_rd_ff, lo_ff}; state_in = S_DONE; end
                  endcase
               end
               default: begin
                  // Pull sequences: RTI, RTS, PLP, PLA.
                  if (step_ff != 3'd0) begin
                     case (op_ff)
                        OP_RTI: begin
                           if (step_ff == 3'd1) begin
                              p_in = (p_ff & PULL_KEEP_MASK) | (mem_rd_ff & PULL_TAKE_MASK);
                           end else if (step_ff == 3'd2) begin
                              lo_in = mem_rd_ff;
                           end else begin
                              pc_in = {mem_rd_ff, lo_ff};
                              state_in = S_DONE;
                           end
                        end
                        OP_RTS: begin
                           if (step_ff == 3'd1) begin
                              lo_in = mem_rd_ff;
                           end else begin
                              pc_in = {mem_rd_ff, lo_ff} + 16'd1;
                              state_in = S_DONE;
                           end
                        end
                        OP_PLP: begin
                           p_in = (p_ff & PULL_KEEP_MASK) | (mem_rd_ff & PULL_TAKE_MASK);
                           pc_in = pc_ff + 16'd1;
                           state_in = S_DONE;
                        end
                        default: begin
                           a_in = mem_rd_ff;
                           p_in = set_nz(p_ff, mem_rd_ff);
                           pc_in = pc_ff + 16'd1;
                           state_in = S_DONE;
                        end
                     endcase
                  end
                  if (state_in != S_DONE) begin
                     sp_in    = sp_ff + 8'd1;
                     mem_addr = {8'h01, sp_ff + 8'd1};
                  end
               end
            endcase
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_ff         <= 8'h00;
         x_ff         <= 8'h00;
         y_ff         <= 8'h00;
         sp_ff        <= 8'hFD;
         p_ff         <= 8'h24;
         pc_ff        <= 16'h0000;
         entry_ff     <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         sp_ff        <= sp_in;
         p_ff         <= p_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_paddr == CSR_ENTRY_ADDR) begin
            entry_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      b1_ff    <= b1_in;
      lo_ff    <= lo_in;
      ptr_ff   <= ptr_in;
      ea_ff    <= ea_in;
      step_ff  <= step_in;
      rdata_ff <= rdata_in;
      bad_ff   <= bad_in;
      if (rsp_load) begin
         rsp_bus.read_data       <= rdata_ff;
         rsp_bus.accumulator     <= a_ff;
         rsp_bus.index_x         <= x_ff;
         rsp_bus.index_y         <= y_ff;
         rsp_bus.stack_pointer   <= sp_ff;
         rsp_bus.status_flags    <= p_ff;
         rsp_bus.program_counter <= pc_ff;
         rsp_bus.executed_opcode <= op_ff;
         rsp_bus.bad_opcode      <= bad_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request taken while an item is in progress");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result posted outside the completion state");

   a_stack_page: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEQ && mem_we) |-> (mem_addr[15:8] == 8'h01))
      else $error("stack write outside page one");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 6502-style execute block. Items go in on the
// request channel with random gaps, results are taken with random stalls, and each
// result is compared against a behavioral model of the core kept here or a fixed expected result.
// ----------------------------------------------------------------------------
module tb;
   import c6502_pkg::*;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  accumulator;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic [7:0]  stack_pointer;
      logic [7:0]  status_flags;
      logic [15:0] program_counter;
      logic [7:0]  executed_opcode;
      logic        bad_opcode;
   } cpu_result_t;

   typedef struct {
      func_type    func;
      logic [15:0] address;
      logic [7:0]  data;
      bit          fixed;
      cpu_result_t result;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   c6502_req_if req();
   c6502_rsp_if rsp();

   cpu6502_instruction_execute dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req),
      .rsp_bus     (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Core state as the block should hold it.
   logic [7:0]  mem_q [65536];
   bit          written_q [65536];
   int          written_list [$];
   logic [7:0]  a_q, x_q, y_q, s_q, p_q;
   logic [15:0] pc_q, entry_q;

   cpu_result_t pending_results [$];
   stim_row_t   directed_rows [$];
   int          errors = 0;
   int          sent_count = 0;
   int          stall_left = 0;
   bit          burst_q = 1'b0;

   task automatic report_mismatch(string field, int got, int want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $time);
      errors++;
   endtask

   function automatic void store_byte(logic [15:0] a, logic [7:0] v);
      mem_q[a] = v;
      if (!written_q[a]) begin
         written_q[a] = 1'b1;
         written_list.push_back(a);
      end
   endfunction

   function automatic void push_byte(logic [7:0] v);
      store_byte({8'h01, s_q}, v);
      s_q = s_q - 8'd1;
   endfunction

   function automatic logic [7:0] pull_byte();
      s_q = s_q + 8'd1;
      return mem_q[{8'h01, s_q}];
   endfunction

   function automatic void set_nz(logic [7:0] v);
      p_q[FL_N] = v[7];
      p_q[FL_Z] = (v == 8'h00);
   endfunction

   function automatic void add_with_carry(logic [7:0] m);
      logic [8:0] s;
      logic [7:0] r, ov;
      s = {1'b0, a_q} + {1'b0, m} + {8'h00, p_q[FL_C]};
      r = s[7:0];
      ov = ~(a_q ^ m) & (a_q ^ r);
      p_q[FL_V] = ov[7];
      p_q[FL_C] = s[8];
      a_q = r;
      set_nz(r);
   endfunction

   function automatic void compare(logic [7:0] r, logic [7:0] m);
      p_q[FL_C] = (r >= m);
      set_nz(r - m);
   endfunction

   function automatic mode_type operand_mode(logic [7:0] op);
      logic [2:0] aaa, bbb;
      mode_type m;
      aaa = op[7:5];
      bbb = op[4:2];
      case (op[1:0])
         2'd1: begin
            if (op == OP_STA_IMM) return M_BAD;
            case (bbb)
               3'd0: return M_INDX;
               3'd1: return M_ZP;
               3'd2: return M_IMM;
               3'd3: return M_ABS;
               3'd4: return M_INDY;
               3'd5: return M_ZPX;
               3'd6: return M_ABSY;
               default: return M_ABSX;
            endcase
         end
         2'd2: begin
            case (bbb)
               3'd0: return aaa == 3'd5 ? M_IMM : M_BAD;
               3'd1: return M_ZP;
               3'd2: return aaa < 3'd4 ? M_ACC : M_BAD;
               3'd3: return M_ABS;
               3'd5: return (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
               3'd7: return aaa == 3'd5 ? M_ABSY : (aaa == 3'd4 ? M_BAD : M_ABSX);
               default: return M_BAD;
            endcase
         end
         2'd0: begin
            case (bbb)
               3'd0: m = M_IMM;
               3'd1: m = M_ZP;
               3'd3: m = M_ABS;
               3'd5: m = M_ZPX;
               3'd7: m = M_ABSX;
               default: m = M_BAD;
            endcase
            case (aaa)
               3'd1: return (bbb == 3'd1 || bbb == 3'd3) ? m : M_BAD;
               3'd4: return (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) ? m : M_BAD;
               3'd5: return m;
               3'd6, 3'd7: return bbb <= 3'd3 ? m : M_BAD;
               default: return M_BAD;
            endcase
         end
         default: return M_BAD;
      endcase
   endfunction

   function automatic bit is_documented(logic [7:0] op);
      case (op)
         OP_BRK, OP_JSR, OP_RTI, OP_RTS, OP_JMP, OP_JMI, OP_PHP, OP_PLP, OP_PHA,
         OP_PLA, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED, OP_DEY,
         OP_INY, OP_DEX, OP_INX, OP_TXA, OP_TYA, OP_TAY, OP_TAX, OP_TSX, OP_TXS,
         OP_NOP: return 1'b1;
         default: return op[4:0] == 5'h10 || operand_mode(op) != M_BAD;
      endcase
   endfunction

   // Returns the first byte the next instruction would read that was never
   // written, or -1 when every byte it touches is defined.
   function automatic int first_unwritten();
      logic [15:0] pc, t, w, ea;
      logic [7:0]  op, b1, zb, zb2, sp;
      mode_type    md;
      int          pulls;
      pc = pc_q;
      if (!written_q[pc]) return pc;
      op = mem_q[pc];
      t = pc + 16'd1;
      if (!written_q[t]) return t;
      b1 = mem_q[t];
      t = pc + 16'd2;
      if (!written_q[t]) return t;
      w = {mem_q[t], b1};
      if (op[4:0] == 5'h10) return -1;
      pulls = 0;
      case (op)
         OP_BRK: begin
            if (!written_q[IRQ_VECTOR]) return IRQ_VECTOR;
            if (!written_q[16'hFFFF]) return 16'hFFFF;
            return -1;
         end
         OP_JMI: begin
            t = {w[15:8], w[7:0] + 8'd1};
            if (!written_q[w]) return w;
            if (!written_q[t]) return t;
            return -1;
         end
         OP_RTI: pulls = 3;
         OP_RTS: pulls = 2;
         OP_PLP, OP_PLA: pulls = 1;
         default: ;
      endcase
      sp = s_q;
      for (int i = 0; i < pulls; i++) begin
         sp = sp + 8'd1;
         if (!written_q[{8'h01, sp}]) return {8'h01, sp};
      end
      md = operand_mode(op);
      // Every special opcode decodes as bad here, so it ends the search too.
      if (pulls > 0 || md == M_BAD) return -1;
      case (md)
         M_ZP:   ea = {8'h00, b1};
         M_ZPX:  ea = {8'h00, 8'(b1 + x_q)};
         M_ZPY:  ea = {8'h00, 8'(b1 + y_q)};
         M_ABS:  ea = w;
         M_ABSX: ea = w + {8'h00, x_q};
         M_ABSY: ea = w + {8'h00, y_q};
         M_INDX: begin
            zb = b1 + x_q;
            zb2 = zb + 8'd1;
            if (!written_q[{8'h00, zb}]) return {8'h00, zb};
            if (!written_q[{8'h00, zb2}]) return {8'h00, zb2};
            ea = {mem_q[{8'h00, zb2}], mem_q[{8'h00, zb}]};
         end
         M_INDY: begin
            zb2 = b1 + 8'd1;
            if (!written_q[{8'h00, b1}]) return {8'h00, b1};
            if (!written_q[{8'h00, zb2}]) return {8'h00, zb2};
            ea = {mem_q[{8'h00, zb2}], mem_q[{8'h00, b1}]} + {8'h00, y_q};
         end
         default: return -1;
      endcase
      if (!written_q[ea]) return ea;
      return -1;
   endfunction

   function automatic bit model_execute(logic [7:0] op);
      logic [15:0] pc, t, w, ea;
      logic [7:0]  b1, m, r, zb, zb2;
      logic [2:0]  aaa;
      mode_type    md;
      bit          c, taken;
      pc = pc_q;
      t = pc + 16'd1;
      b1 = mem_q[t];
      t = pc + 16'd2;
      w = {mem_q[t], b1};
      ea = 16'h0000;
      aaa = op[7:5];
      if (op[4:0] == 5'h10) begin
         case (op[7:6])
            2'd0: taken = p_q[FL_N];
            2'd1: taken = p_q[FL_V];
            2'd2: taken = p_q[FL_C];
            default: taken = p_q[FL_Z];
         endcase
         pc_q = pc + 16'd2;
         if (taken == op[5]) pc_q = pc_q + {{8{b1[7]}}, b1};
         return 1'b1;
      end
      pc_q = pc + 16'd1;
      case (op)
         OP_BRK: begin
            t = pc + 16'd2;
            push_byte(t[15:8]);
            push_byte(t[7:0]);
            push_byte(p_q | PUSH_STATUS_SET);
            p_q[FL_I] = 1'b1;
            pc_q = {mem_q[16'hFFFF], mem_q[IRQ_VECTOR]};
            return 1'b1;
         end
         OP_JSR: begin
            t = pc + 16'd2;
            push_byte(t[15:8]);
            push_byte(t[7:0]);
            pc_q = w;
            return 1'b1;
         end
         OP_RTI: begin
            m = pull_byte();
            p_q = (p_q & PULL_KEEP_MASK) | (m & PULL_TAKE_MASK);
            r = pull_byte();
            m = pull_byte();
            pc_q = {m, r};
            return 1'b1;
         end
         OP_RTS: begin
            r = pull_byte();
            m = pull_byte();
            pc_q = {m, r} + 16'd1;
            return 1'b1;
         end
         OP_JMP: begin pc_q = w; return 1'b1; end
         OP_JMI: begin
            // The pointer's high byte comes from the same page.
            t = {w[15:8], w[7:0] + 8'd1};
            pc_q = {mem_q[t], mem_q[w]};
            return 1'b1;
         end
         OP_PHP: begin push_byte(p_q | PUSH_STATUS_SET); return 1'b1; end
         OP_PLP: begin
            m = pull_byte();
            p_q = (p_q & PULL_KEEP_MASK) | (m & PULL_TAKE_MASK);
            return 1'b1;
         end
         OP_PHA: begin push_byte(a_q); return 1'b1; end
         OP_PLA: begin a_q = pull_byte(); set_nz(a_q); return 1'b1; end
         OP_CLC: begin p_q[FL_C] = 1'b0; return 1'b1; end
         OP_SEC: begin p_q[FL_C] = 1'b1; return 1'b1; end
         OP_CLI: begin p_q[FL_I] = 1'b0; return 1'b1; end
         OP_SEI: begin p_q[FL_I] = 1'b1; return 1'b1; end
         OP_CLV: begin p_q[FL_V] = 1'b0; return 1'b1; end
         OP_CLD: begin p_q[FL_D] = 1'b0; return 1'b1; end
         OP_SED: begin p_q[FL_D] = 1'b1; return 1'b1; end
         OP_DEY: begin y_q = y_q - 8'd1; set_nz(y_q); return 1'b1; end
         OP_INY: begin y_q = y_q + 8'd1; set_nz(y_q); return 1'b1; end
         OP_DEX: begin x_q = x_q - 8'd1; set_nz(x_q); return 1'b1; end
         OP_INX: begin x_q = x_q + 8'd1; set_nz(x_q); return 1'b1; end
         OP_TXA: begin a_q = x_q; set_nz(a_q); return 1'b1; end
         OP_TYA: begin a_q = y_q; set_nz(a_q); return 1'b1; end
         OP_TAY: begin y_q = a_q; set_nz(y_q); return 1'b1; end
         OP_TAX: begin x_q = a_q; set_nz(x_q); return 1'b1; end
         OP_TSX: begin x_q = s_q; set_nz(x_q); return 1'b1; end
         OP_TXS: begin s_q = x_q; return 1'b1; end
         OP_NOP: return 1'b1;
         default: ;
      endcase

      md = operand_mode(op);
      if (md == M_BAD) begin
         pc_q = pc;
         return 1'b0;
      end
      case (md)
         M_ZP:   ea = {8'h00, b1};
         M_ZPX:  ea = {8'h00, 8'(b1 + x_q)};
         M_ZPY:  ea = {8'h00, 8'(b1 + y_q)};
         M_ABS:  ea = w;
         M_ABSX: ea = w + {8'h00, x_q};
         M_ABSY: ea = w + {8'h00, y_q};
         M_INDX: begin
            zb = b1 + x_q;
            zb2 = zb + 8'd1;
            ea = {mem_q[{8'h00, zb2}], mem_q[{8'h00, zb}]};
         end
         M_INDY: begin
            zb2 = b1 + 8'd1;
            ea = {mem_q[{8'h00, zb2}], mem_q[{8'h00, b1}]} + {8'h00, y_q};
         end
         default: ;
      endcase
      if (md == M_ACC) pc_q = pc + 16'd1;
      else if (md == M_ABS || md == M_ABSX || md == M_ABSY) pc_q = pc + 16'd3;
      else pc_q = pc + 16'd2;
      m = (md == M_IMM) ? b1 : (md == M_ACC) ? a_q : mem_q[ea];

      case (op[1:0])
         2'd1: begin
            case (aaa)
               3'd0: begin a_q = a_q | m; set_nz(a_q); end
               3'd1: begin a_q = a_q & m; set_nz(a_q); end
               3'd2: begin a_q = a_q ^ m; set_nz(a_q); end
               3'd3: add_with_carry(m);
               3'd4: store_byte(ea, a_q);
               3'd5: begin a_q = m; set_nz(m); end
               3'd6: compare(a_q, m);
               default: add_with_carry(~m);
            endcase
         end
         2'd2: begin
            c = p_q[FL_C];
            case (aaa)
               3'd0: begin p_q[FL_C] = m[7]; r = {m[6:0], 1'b0}; end
               3'd1: begin p_q[FL_C] = m[7]; r = {m[6:0], c}; end
               3'd2: begin p_q[FL_C] = m[0]; r = {1'b0, m[7:1]}; end
               3'd3: begin p_q[FL_C] = m[0]; r = {c, m[7:1]}; end
               3'd4: begin store_byte(ea, x_q); return 1'b1; end
               3'd5: begin x_q = m; set_nz(m); return 1'b1; end
               3'd6: r = m - 8'd1;
               default: r = m + 8'd1;
            endcase
            set_nz(r);
            if (md == M_ACC) a_q = r;
            else store_byte(ea, r);
         end
         default: begin
            case (aaa)
               3'd1: p_q = (p_q & BIT_KEEP_MASK) | (m & BIT_TAKE_MASK)
                           | ((a_q & m) == 8'h00 ? 8'h02 : 8'h00);
               3'd4: store_byte(ea, y_q);
               3'd5: begin y_q = m; set_nz(m); end
               3'd6: compare(y_q, m);
               default: compare(x_q, m);
            endcase
         end
      endcase
      return 1'b1;
   endfunction

   function automatic cpu_result_t cpu_step(func_type f, logic [15:0] a, logic [7:0] d);
      cpu_result_t r;
      r = '0;
      case (f)
         FUNC_WRITE: store_byte(a, d);
         FUNC_READ:  r.read_data = mem_q[a];
         FUNC_EXEC: begin
            r.executed_opcode = mem_q[pc_q];
            r.bad_opcode = !model_execute(r.executed_opcode);
         end
         default: pc_q = entry_q;
      endcase
      r.accumulator = a_q;
      r.index_x = x_q;
      r.index_y = y_q;
      r.stack_pointer = s_q;
      r.status_flags = p_q;
      r.program_counter = pc_q;
      return r;
   endfunction

   task automatic send_item(func_type f, logic [15:0] a, logic [7:0] d, bit fixed,
                            cpu_result_t lit);
      int gap;
      cpu_result_t r;
      gap = burst_q ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= f;
      req.address <= a;
      req.write_data <= d;
      do @(posedge clock); while (!req.ready);
      r = cpu_step(f, a, d);
      pending_results.push_back(fixed ? lit : r);
      sent_count++;
   endtask

   // Executes are preceded by writes of any byte they would otherwise read
   // undefined.
   task automatic issue(func_type f, logic [15:0] a, logic [7:0] d, bit fixed,
                        cpu_result_t lit);
      int miss;
      if (f == FUNC_EXEC) begin
         miss = first_unwritten();
         while (miss >= 0) begin
            send_item(FUNC_WRITE, miss[15:0], 8'($urandom), 1'b0, '0);
            miss = first_unwritten();
         end
      end
      send_item(f, a, d, fixed, lit);
   endtask

   task automatic drain();
      if (req.valid) req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_entry(logic [15:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ENTRY_ADDR;
      csr_pwdata <= {16'h0000, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      entry_q = v;
      @(posedge clock);
   endtask

   function automatic void add_row(func_type f, logic [15:0] a, logic [7:0] d);
      directed_rows.push_back('{f, a, d, 1'b0, '0});
   endfunction

   function automatic void add_fixed(func_type f, logic [15:0] a, cpu_result_t r);
      directed_rows.push_back('{f, a, 8'h00, 1'b1, r});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               cpu_result_t e;
               e = pending_results.pop_front();
               if (rsp.read_data !== e.read_data)
                  report_mismatch("read_data", rsp.read_data, e.read_data);
               if (rsp.accumulator !== e.accumulator)
                  report_mismatch("accumulator", rsp.accumulator, e.accumulator);
               if (rsp.index_x !== e.index_x)
                  report_mismatch("index_x", rsp.index_x, e.index_x);
               if (rsp.index_y !== e.index_y)
                  report_mismatch("index_y", rsp.index_y, e.index_y);
               if (rsp.stack_pointer !== e.stack_pointer)
                  report_mismatch("stack_pointer", rsp.stack_pointer, e.stack_pointer);
               if (rsp.status_flags !== e.status_flags)
                  report_mismatch("status_flags", rsp.status_flags, e.status_flags);
               if (rsp.program_counter !== e.program_counter)
                  report_mismatch("program_counter", rsp.program_counter,
                                  e.program_counter);
               if (rsp.executed_opcode !== e.executed_opcode)
                  report_mismatch("executed_opcode", rsp.executed_opcode,
                                  e.executed_opcode);
               if (rsp.bad_opcode !== e.bad_opcode)
                  report_mismatch("bad_opcode", rsp.bad_opcode, e.bad_opcode);
            end
            stall_left = burst_q ? 0 : $urandom_range(0, 18);
         end
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int k, pick;
      logic [7:0] op;
      logic [15:0] entries [4];

      req.valid <= 1'b0;
      req.func <= FUNC_WRITE;
      req.address <= 16'h0000;
      req.write_data <= 8'h00;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ENTRY_ADDR;
      csr_pwdata <= 32'h0;
      a_q = 8'h00; x_q = 8'h00; y_q = 8'h00; s_q = 8'hFD; p_q = 8'h24;
      pc_q = 16'h0000; entry_q = 16'h0000;

      add_fixed(FUNC_RESTART, 16'h0000,
                '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 16'h0000, 8'h00, 1'b0});
      add_row(FUNC_WRITE, 16'hFFFF, 8'hFF);
      add_fixed(FUNC_READ, 16'hFFFF,
                '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 16'h0000, 8'h00, 1'b0});
      add_row(FUNC_WRITE, 16'h0000, 8'h02);
      add_fixed(FUNC_EXEC, 16'h0000,
                '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 16'h0000, 8'h02, 1'b1});
      add_row(FUNC_WRITE, 16'h0000, 8'hA9);   // LDA #$80
      add_row(FUNC_WRITE, 16'h0001, 8'h80);
      add_row(FUNC_EXEC, 16'h0000, 8'h00);
      add_row(FUNC_WRITE, 16'h0002, 8'h69);   // ADC #$80: carry and overflow
      add_row(FUNC_WRITE, 16'h0003, 8'h80);
      add_row(FUNC_EXEC, 16'h0000, 8'h00);
      add_row(FUNC_WRITE, 16'h0004, OP_BRK);
      add_row(FUNC_WRITE, IRQ_VECTOR, 8'h10);
      add_row(FUNC_WRITE, 16'hFF10, OP_RTI);
      add_row(FUNC_EXEC, 16'h0000, 8'h00);
      add_row(FUNC_EXEC, 16'h0000, 8'h00);
      add_row(FUNC_WRITE, 16'h0006, OP_JMI);  // pointer at a page end
      add_row(FUNC_WRITE, 16'h0007, 8'hFF);
      add_row(FUNC_WRITE, 16'h0008, 8'h12);
      add_row(FUNC_WRITE, 16'h12FF, 8'h34);
      add_row(FUNC_WRITE, 16'h1200, 8'h56);
      add_row(FUNC_EXEC, 16'h0000, 8'h00);
      add_row(FUNC_READ, 16'h0000, 8'h00);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue(directed_rows[i].func, directed_rows[i].address, directed_rows[i].data,
               directed_rows[i].fixed, directed_rows[i].result);

      entries[0] = 16'hFFFF;
      entries[1] = 16'h0000;
      entries[2] = 16'($urandom);
      entries[3] = 16'($urandom);
      for (int ph = 0; ph < 4; ph++) begin
         // The sender holds off here until every outstanding result is back.
         drain();
         write_entry(entries[ph]);
         burst_q = (ph == 1);
         issue(FUNC_RESTART, 16'h0000, 8'h00, 1'b0, '0);
         while (sent_count < 300 * (ph + 1)) begin
            k = $urandom_range(0, 99);
            if (k < 8) begin
               issue(FUNC_WRITE, 16'($urandom), 8'($urandom), 1'b0, '0);
            end else if (k < 16) begin
               pick = $urandom_range(0, written_list.size() - 1);
               issue(FUNC_READ, written_list[pick][15:0], 8'($urandom), 1'b0, '0);
            end else if (k < 20) begin
               issue(FUNC_RESTART, 16'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
               if ($urandom_range(0, 99) < 55) begin
                  op = 8'($urandom);
                  if ($urandom_range(0, 99) < 85)
                     while (!is_documented(op)) op = 8'($urandom);
                  issue(FUNC_WRITE, pc_q, op, 1'b0, '0);
               end
               issue(FUNC_EXEC, 16'($urandom), 8'($urandom), 1'b0, '0);
            end
         end
      end
      burst_q = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/c6502_pkg.sv
rtl/c6502_ifs.sv
rtl/cpu6502_instruction_execute.sv
bench/tb.sv
